FILE: hw/rtl/mrfe_pkg.sv
// ----------------------------------------------------------------------------
// mrfe_pkg
// Shared types and constants of the mask rectangle fill engine.
// ----------------------------------------------------------------------------
package mrfe_pkg;

  // Mask geometry
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int IDX_X_W     = $clog2(MAX_WIDTH);
  localparam int IDX_Y_W     = $clog2(MAX_HEIGHT);

  // Field widths
  localparam int DIM_W   = 9;   // size registers
  localparam int CRD_W   = 16;  // coordinate fields
  localparam int SUM_W   = CRD_W + 1;
  localparam int PIX_W   = 8;
  localparam int OP_W    = 2;
  localparam int BLEND_W = 2;
  localparam int CIDX_W  = 1;

  localparam logic [PIX_W-1:0] FULL_LEVEL = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_FILL  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [BLEND_W-1:0] {
    BLEND_REPLACE  = 2'd0,
    BLEND_KEEP_LIT = 2'd1
  } blend_e;

  typedef enum logic [CIDX_W-1:0] {
    REG_BUFFER_WIDTH  = 1'b0,
    REG_BUFFER_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_ADDR,
    ST_RD_MEM,
    ST_RD_DATA,
    ST_F_SUM,
    ST_F_CLAMP,
    ST_F_LIMIT,
    ST_F_BASE,
    ST_F_WALK,
    ST_F_DRAIN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CRD_W-1:0]   dest_x;
    logic [CRD_W-1:0]   dest_y;
    logic [CRD_W-1:0]   dest_w;
    logic [CRD_W-1:0]   dest_h;
    logic [CRD_W-1:0]   clip_x;
    logic [CRD_W-1:0]   clip_y;
    logic [CRD_W-1:0]   clip_w;
    logic [CRD_W-1:0]   clip_h;
    logic [BLEND_W-1:0] blend;
    logic [PIX_W-1:0]   fill_value;
  } item_t;

endpackage

FILE: hw/rtl/mrfe_ram.sv
// ----------------------------------------------------------------------------
// mrfe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mrfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hw/rtl/mask_rect_fill_engine.sv
// ----------------------------------------------------------------------------
// mask_rect_fill_engine
// Clipped rectangle fill, pixel read and clear on an 8-bit light mask.
// ----------------------------------------------------------------------------
// The mask lives in one 64K x 8 RAM with a registered read. After reset the
// block sweeps the RAM to zero, one pixel a cycle, before it takes its first
// item; size register writes are taken meanwhile. Items are handled one at a
// time. A fill runs the clip arithmetic through the sum, clamp, limit and
// base states. If the clipped rectangle is not empty, a walk follows that
// issues one RAM read and one write back per cycle (the write follows the
// read in the next cycle to apply the keep-lit test), then a drain state.
// The finish state posts the result. A fill with an unknown blend code goes
// from the sum state to finish, a read passes the address, memory and data
// states, and a clear runs the same zeroing sweep. The result waits in an
// output register, so the next item is taken while it is still stalled.
module mask_rect_fill_engine
  import mrfe_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration
  input  logic                     cfg_we_i,
  input  logic [CIDX_W-1:0]        cfg_idx_i,
  input  logic [DIM_W-1:0]         cfg_data_i,
  // item channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [OP_W-1:0]          op_i,
  input  logic signed [CRD_W-1:0]  dest_x_i,
  input  logic signed [CRD_W-1:0]  dest_y_i,
  input  logic signed [CRD_W-1:0]  dest_w_i,
  input  logic signed [CRD_W-1:0]  dest_h_i,
  input  logic signed [CRD_W-1:0]  clip_x_i,
  input  logic signed [CRD_W-1:0]  clip_y_i,
  input  logic signed [CRD_W-1:0]  clip_w_i,
  input  logic signed [CRD_W-1:0]  clip_h_i,
  input  logic [BLEND_W-1:0]       blend_i,
  input  logic [PIX_W-1:0]         fill_value_i,
  // result channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [PIX_W-1:0]         pixel_value_o,
  output logic                     fully_lit_o,
  output logic                     out_of_range_o
);

  function automatic logic signed [SUM_W-1:0] sx(input logic [CRD_W-1:0] v);
    sx = $signed({v[CRD_W-1], v});
  endfunction

  function automatic logic signed [SUM_W-1:0] clamp_span(
    input logic signed [SUM_W-1:0] v,
    input logic signed [SUM_W-1:0] lo,
    input logic signed [SUM_W-1:0] hi
  );
    if (v < lo) begin
      clamp_span = lo;
    end else if (v > hi) begin
      clamp_span = hi;
    end else begin
      clamp_span = v;
    end
  endfunction

  state_e state_q, state_d;

  // configuration
  logic [DIM_W-1:0] buf_w_q, buf_h_q;
  logic [DIM_W-1:0] act_w, act_h;
  logic signed [SUM_W-1:0] act_w_s, act_h_s;

  // item and work registers
  item_t item_q;
  logic signed [SUM_W-1:0] x_end_q, y_end_q, x_hi_q, y_hi_q;
  logic signed [SUM_W-1:0] x0_q, x1_q, y0_q, y1_q;
  logic [DIM_W-1:0]  x_q, y_q, x_start_q, x_stop_q, y_stop_q;
  logic [ADDR_W-1:0] row_base_q, rd_addr_q, clr_cnt_q, wr_addr_q;
  logic              wr_pend_q, clr_result_q;
  logic              res_oor_q;
  logic [PIX_W-1:0]  res_pix_q;

  // output register
  logic              out_valid_q;
  logic [PIX_W-1:0]  out_pix_q;
  logic              out_lit_q, out_oor_q;

  // RAM port signals
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr, walk_addr;
  logic [PIX_W-1:0]  ram_wdata, ram_rdata;

  logic in_xfer, out_free, row_last, col_last, fill_empty, clr_last;

  assign act_w   = (buf_w_q > DIM_W'(MAX_WIDTH))  ? DIM_W'(MAX_WIDTH)  : buf_w_q;
  assign act_h   = (buf_h_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : buf_h_q;
  assign act_w_s = $signed({{(SUM_W-DIM_W){1'b0}}, act_w});
  assign act_h_s = $signed({{(SUM_W-DIM_W){1'b0}}, act_h});

  assign in_xfer    = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign walk_addr  = row_base_q + ADDR_W'(x_q);
  assign col_last   = (x_q + 1'b1) == x_stop_q;
  assign row_last   = (y_q + 1'b1) == y_stop_q;
  assign fill_empty = (x0_q >= x1_q) || (y0_q >= y1_q);
  assign clr_last   = clr_cnt_q == ADDR_W'(STORE_DEPTH - 1);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    ram_raddr  = walk_addr;
    ram_we     = wr_pend_q &&
                 ((item_q.blend == BLEND_REPLACE) || (ram_rdata != FULL_LEVEL));
    ram_waddr  = wr_addr_q;
    ram_wdata  = item_q.fill_value;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        if (clr_last) begin
          state_d = clr_result_q ? ST_FINISH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          unique case (op_e'(op_i))
            OP_FILL:  state_d = ST_F_SUM;
            OP_READ:  state_d = ST_RD_ADDR;
            OP_CLEAR: state_d = ST_CLEAR;
            default:  state_d = ST_FINISH;
          endcase
        end
      end
      ST_RD_ADDR: state_d = ST_RD_MEM;
      ST_RD_MEM: begin
        ram_re    = 1'b1;
        ram_raddr = rd_addr_q;
        state_d   = ST_RD_DATA;
      end
      ST_RD_DATA: state_d = ST_FINISH;
      ST_F_SUM: begin
        unique case (blend_e'(item_q.blend))
          BLEND_REPLACE, BLEND_KEEP_LIT: state_d = ST_F_CLAMP;
          default:                       state_d = ST_FINISH;
        endcase
      end
      ST_F_CLAMP: state_d = ST_F_LIMIT;
      ST_F_LIMIT: state_d = ST_F_BASE;
      ST_F_BASE:  state_d = fill_empty ? ST_FINISH : ST_F_WALK;
      ST_F_WALK: begin
        ram_re = 1'b1;
        if (col_last && row_last) begin
          state_d = ST_F_DRAIN;
        end
      end
      ST_F_DRAIN: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_w_q      <= DIM_W'(MAX_WIDTH);
      buf_h_q      <= DIM_W'(MAX_HEIGHT);
      clr_cnt_q    <= '0;
      clr_result_q <= 1'b0;
      wr_pend_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_BUFFER_WIDTH:  buf_w_q <= cfg_data_i;
          REG_BUFFER_HEIGHT: buf_h_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end else if (in_xfer) begin
        clr_cnt_q    <= '0;
        clr_result_q <= 1'b1;
      end
      // write back follows the walk read in the next cycle
      wr_pend_q <= (state_q == ST_F_WALK);
      if ((state_q == ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    wr_addr_q <= walk_addr;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_q.op         <= op_i;
          item_q.dest_x     <= dest_x_i;
          item_q.dest_y     <= dest_y_i;
          item_q.dest_w     <= dest_w_i;
          item_q.dest_h     <= dest_h_i;
          item_q.clip_x     <= clip_x_i;
          item_q.clip_y     <= clip_y_i;
          item_q.clip_w     <= clip_w_i;
          item_q.clip_h     <= clip_h_i;
          item_q.blend      <= blend_i;
          item_q.fill_value <= fill_value_i;
          res_pix_q         <= '0;
          res_oor_q         <= 1'b0;
        end
      end
      ST_RD_ADDR: begin
        res_oor_q <= item_q.dest_x[CRD_W-1] || item_q.dest_y[CRD_W-1] ||
                     (sx(item_q.dest_x) >= act_w_s) || (sx(item_q.dest_y) >= act_h_s);
        rd_addr_q <= ADDR_W'(ADDR_W'(item_q.dest_y[IDX_Y_W-1:0]) * ADDR_W'(act_w)) +
                     ADDR_W'(item_q.dest_x[IDX_X_W-1:0]);
      end
      ST_RD_DATA: begin
        res_pix_q <= res_oor_q ? '0 : ram_rdata;
      end
      ST_F_SUM: begin
        x_end_q <= sx(item_q.dest_x) + sx(item_q.dest_w);
        y_end_q <= sx(item_q.dest_y) + sx(item_q.dest_h);
        x_hi_q  <= sx(item_q.clip_x) + sx(item_q.clip_w);
        y_hi_q  <= sx(item_q.clip_y) + sx(item_q.clip_h);
      end
      ST_F_CLAMP: begin
        x0_q <= clamp_span(sx(item_q.dest_x), sx(item_q.clip_x), x_hi_q);
        x1_q <= clamp_span(x_end_q, sx(item_q.clip_x), x_hi_q);
        y0_q <= clamp_span(sx(item_q.dest_y), sx(item_q.clip_y), y_hi_q);
        y1_q <= clamp_span(y_end_q, sx(item_q.clip_y), y_hi_q);
      end
      ST_F_LIMIT: begin
        // keep the span inside the active buffer
        if (x0_q < 0) x0_q <= '0;
        if (y0_q < 0) y0_q <= '0;
        if (x1_q > act_w_s) x1_q <= act_w_s;
        if (y1_q > act_h_s) y1_q <= act_h_s;
      end
      ST_F_BASE: begin
        x_q        <= x0_q[DIM_W-1:0];
        x_start_q  <= x0_q[DIM_W-1:0];
        x_stop_q   <= x1_q[DIM_W-1:0];
        y_q        <= y0_q[DIM_W-1:0];
        y_stop_q   <= y1_q[DIM_W-1:0];
        row_base_q <= ADDR_W'(ADDR_W'(y0_q[DIM_W-1:0]) * ADDR_W'(act_w));
      end
      ST_F_WALK: begin
        if (col_last) begin
          x_q        <= x_start_q;
          y_q        <= y_q + 1'b1;
          row_base_q <= row_base_q + ADDR_W'(act_w);
        end else begin
          x_q <= x_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_FINISH) && out_free) begin
      out_pix_q <= res_pix_q;
      out_lit_q <= res_pix_q == FULL_LEVEL;
      out_oor_q <= res_oor_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_value_o  = out_pix_q;
  assign fully_lit_o    = out_lit_q;
  assign out_of_range_o = out_oor_q;

  mrfe_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: hw/rtl/mrfe_checker.sv
// ----------------------------------------------------------------------------
// mrfe_checker
// Port-level checks on the mask rectangle fill engine, bound to the top level.
// ----------------------------------------------------------------------------
module mrfe_checker
  import mrfe_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [PIX_W-1:0] pixel_value_o,
  input logic             fully_lit_o,
  input logic             out_of_range_o
);

  // busy in the cycle after every item transfer
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item taken on back-to-back cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_value_o) &&
    $stable(fully_lit_o) && $stable(out_of_range_o))
    else $error("stalled result changed");

  // a new result is only posted while the item side is held off
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a pending item");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> pixel_value_o == '0 && !fully_lit_o)
    else $error("out of range read returned data");

  a_lit_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fully_lit_o |-> pixel_value_o == FULL_LEVEL)
    else $error("fully lit flag with a level below full");

endmodule

bind mask_rect_fill_engine mrfe_checker u_mrfe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .pixel_value_o  (pixel_value_o),
  .fully_lit_o    (fully_lit_o),
  .out_of_range_o (out_of_range_o)
);

FILE: tb/mask_rect_fill_checker.sv
// ----------------------------------------------------------------------------
// mask_rect_fill_checker
// Watches the item, result and size register ports of the fill engine, keeps
// its own copy of the light mask and the buffer size, works out the readout of
// every accepted item and compares each result transfer, field by field, with
// the oldest readout still waiting.
// ----------------------------------------------------------------------------
module mask_rect_fill_checker
  import mrfe_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CIDX_W-1:0]        cfg_idx_i,
  input  logic [DIM_W-1:0]         cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_o,
  input  logic [OP_W-1:0]          op_i,
  input  logic signed [CRD_W-1:0]  dest_x_i,
  input  logic signed [CRD_W-1:0]  dest_y_i,
  input  logic signed [CRD_W-1:0]  dest_w_i,
  input  logic signed [CRD_W-1:0]  dest_h_i,
  input  logic signed [CRD_W-1:0]  clip_x_i,
  input  logic signed [CRD_W-1:0]  clip_y_i,
  input  logic signed [CRD_W-1:0]  clip_w_i,
  input  logic signed [CRD_W-1:0]  clip_h_i,
  input  logic [BLEND_W-1:0]       blend_i,
  input  logic [PIX_W-1:0]         fill_value_i,
  input  logic                     out_valid_o,
  input  logic                     out_stall_i,
  input  logic [PIX_W-1:0]         pixel_value_o,
  input  logic                     fully_lit_o,
  input  logic                     out_of_range_o,
  output int                       fail_count_o,
  output int                       outstanding_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             fully_lit;
    logic             out_of_range;
  } readout_t;

  logic [PIX_W-1:0] mask_mem [0:STORE_DEPTH-1];
  logic [DIM_W-1:0] width_cfg;
  logic [DIM_W-1:0] height_cfg;
  readout_t         expected_readouts [$];
  readout_t         want;
  item_t            bus_item;
  int               errs;

  assign bus_item = {op_i, dest_x_i, dest_y_i, dest_w_i, dest_h_i,
                     clip_x_i, clip_y_i, clip_w_i, clip_h_i, blend_i, fill_value_i};

  function automatic int sx(logic [CRD_W-1:0] v);
    return int'($signed(v));
  endfunction

  function automatic int clamp_to(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Update the mask copy for one item and return what the block should report.
  function automatic readout_t apply_mask_item(item_t it);
    readout_t r;
    int w, h, lo, hi, x0, x1, y0, y1, px, py;
    int unsigned addr;
    r = '0;
    w = (width_cfg > MAX_WIDTH) ? MAX_WIDTH : int'(width_cfg);
    h = (height_cfg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_cfg);
    case (it.op)
      OP_FILL: begin
        if (it.blend == BLEND_REPLACE || it.blend == BLEND_KEEP_LIT) begin
          lo = sx(it.clip_x);
          hi = lo + sx(it.clip_w);
          x0 = clamp_to(sx(it.dest_x), lo, hi);
          x1 = clamp_to(sx(it.dest_x) + sx(it.dest_w), lo, hi);
          lo = sx(it.clip_y);
          hi = lo + sx(it.clip_h);
          y0 = clamp_to(sx(it.dest_y), lo, hi);
          y1 = clamp_to(sx(it.dest_y) + sx(it.dest_h), lo, hi);
          if (x0 < 0) x0 = 0;
          if (y0 < 0) y0 = 0;
          if (x1 > w) x1 = w;
          if (y1 > h) y1 = h;
          for (py = y0; py < y1; py++) begin
            for (px = x0; px < x1; px++) begin
              addr = py * w + px;
              if (!(it.blend == BLEND_KEEP_LIT && mask_mem[addr] == FULL_LEVEL)) begin
                mask_mem[addr] = it.fill_value;
              end
            end
          end
        end
      end
      OP_READ: begin
        px = sx(it.dest_x);
        py = sx(it.dest_y);
        if (px < 0 || py < 0 || px >= w || py >= h) begin
          r.out_of_range = 1'b1;
        end else begin
          r.pixel_value = mask_mem[py * w + px];
          r.fully_lit   = (r.pixel_value == FULL_LEVEL);
        end
      end
      OP_CLEAR: begin
        foreach (mask_mem[i]) mask_mem[i] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (mask_mem[i]) mask_mem[i] = '0;
      width_cfg  = 9'd256;
      height_cfg = 9'd256;
      expected_readouts.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      errs = 0;
      // Retire the result first: it belongs to an item taken at an earlier edge.
      if (out_valid_o && !out_stall_i) begin
        if (expected_readouts.size() == 0) begin
          $error("unexpected result: pixel_value %0d fully_lit %0d out_of_range %0d",
                 pixel_value_o, fully_lit_o, out_of_range_o);
          errs++;
        end else begin
          want = expected_readouts.pop_front();
          if (pixel_value_o !== want.pixel_value) begin
            $error("pixel_value: expected %0d, got %0d", want.pixel_value, pixel_value_o);
            errs++;
          end
          if (fully_lit_o !== want.fully_lit) begin
            $error("fully_lit: expected %0d, got %0d", want.fully_lit, fully_lit_o);
            errs++;
          end
          if (out_of_range_o !== want.out_of_range) begin
            $error("out_of_range: expected %0d, got %0d", want.out_of_range, out_of_range_o);
            errs++;
          end
        end
      end
      if (errs != 0) begin
        fail_count_o <= fail_count_o + errs;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_BUFFER_WIDTH) width_cfg = cfg_data_i;
        else height_cfg = cfg_data_i;
      end
      if (in_valid_i && !in_stall_o) begin
        expected_readouts.push_back(apply_mask_item(bus_item));
      end
      outstanding_o <= expected_readouts.size();
    end
  end

endmodule

FILE: tb/mask_rect_fill_engine_test.sv
// ----------------------------------------------------------------------------
// mask_rect_fill_engine_test
// Drives fill, read, clear and unused op items into the fill engine under a
// series of buffer sizes, with random idle cycles on both sides, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module mask_rect_fill_engine_test
  import mrfe_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OP_W-1:0]    OP_UNUSED   = 2'd3;
  localparam logic [BLEND_W-1:0] BLEND_NOP_A = 2'd2;
  localparam logic [BLEND_W-1:0] BLEND_NOP_B = 2'd3;
  localparam int PHASE_ITEMS = 85;
  localparam int N_PHASES    = 11;
  localparam int ITEM_W      = $bits(item_t);

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CIDX_W-1:0]        cfg_idx_i;
  logic [DIM_W-1:0]         cfg_data_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [OP_W-1:0]          op_i;
  logic signed [CRD_W-1:0]  dest_x_i;
  logic signed [CRD_W-1:0]  dest_y_i;
  logic signed [CRD_W-1:0]  dest_w_i;
  logic signed [CRD_W-1:0]  dest_h_i;
  logic signed [CRD_W-1:0]  clip_x_i;
  logic signed [CRD_W-1:0]  clip_y_i;
  logic signed [CRD_W-1:0]  clip_w_i;
  logic signed [CRD_W-1:0]  clip_h_i;
  logic [BLEND_W-1:0]       blend_i;
  logic [PIX_W-1:0]         fill_value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [PIX_W-1:0]         pixel_value_o;
  logic                     fully_lit_o;
  logic                     out_of_range_o;

  int   fail_count;
  int   pending_count;
  int   geo_w;
  int   geo_h;
  logic steady_run;

  int phase_w [N_PHASES] = '{256, 1, 37, 256, 1, 0, 128, 511, 300, 200, 256};
  int phase_h [N_PHASES] = '{256, 1, 200, 1, 256, 128, 0, 300, 511, 255, 256};

  mask_rect_fill_engine u_dut (.*);

  mask_rect_fill_checker u_checker (
    .*,
    .fail_count_o  (fail_count),
    .outstanding_o (pending_count)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic item_t bare_cmd(logic [OP_W-1:0] code);
    item_t it;
    it    = '0;
    it.op = code;
    return it;
  endfunction

  function automatic item_t read_cmd(int x, int y);
    item_t it;
    it        = bare_cmd(OP_READ);
    it.dest_x = 16'(x);
    it.dest_y = 16'(y);
    return it;
  endfunction

  function automatic item_t fill_cmd(int x, int y, int w, int h, int cx, int cy, int cw,
                                     int ch, logic [BLEND_W-1:0] mode, logic [PIX_W-1:0] val);
    item_t it;
    it            = bare_cmd(OP_FILL);
    it.dest_x     = 16'(x);
    it.dest_y     = 16'(y);
    it.dest_w     = 16'(w);
    it.dest_h     = 16'(h);
    it.clip_x     = 16'(cx);
    it.clip_y     = 16'(cy);
    it.clip_w     = 16'(cw);
    it.clip_h     = 16'(ch);
    it.blend      = mode;
    it.fill_value = val;
    return it;
  endfunction

  // Mostly well-formed fills and reads around the active buffer; some noise.
  function automatic item_t random_item();
    item_t it;
    int    kind, shape, b;
    logic [BLEND_W-1:0] mode;
    kind = $urandom_range(0, 299);
    if (kind == 0) return bare_cmd(OP_CLEAR);
    it = ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
    if (kind <= 3) begin
      it.op = OP_UNUSED;
      return it;
    end
    if (kind < 120) begin
      it.op = OP_READ;
      shape = $urandom_range(0, 99);
      if (shape < 70) begin
        it.dest_x = 16'(pick(0, (geo_w > 0) ? geo_w - 1 : 0));
        it.dest_y = 16'(pick(0, (geo_h > 0) ? geo_h - 1 : 0));
      end else if (shape < 85) begin
        it.dest_x = 16'(pick(-2, geo_w + 1));
        it.dest_y = 16'(pick(-2, geo_h + 1));
      end
      return it;
    end
    b = $urandom_range(0, 99);
    if (b < 45) mode = BLEND_REPLACE;
    else if (b < 85) mode = BLEND_KEEP_LIT;
    else mode = $urandom_range(0, 1) ? BLEND_NOP_A : BLEND_NOP_B;
    it = fill_cmd(pick(-8, geo_w + 8), pick(-8, geo_h + 8), pick(-4, 24), pick(-4, 24),
                  0, 0, geo_w, geo_h, mode,
                  ($urandom_range(0, 3) == 0) ? FULL_LEVEL : 8'($urandom));
    shape = $urandom_range(0, 99);
    if (shape == 0) begin
      it.dest_x = 16'(pick(-16, 64));
      it.dest_y = 16'(pick(-16, 64));
      it.dest_w = 16'(pick(0, 256));
      it.dest_h = 16'(pick(0, 256));
    end else if (shape < 60) begin
      // clip to the whole buffer, as set above
    end else if (shape < 80) begin
      it.clip_x = 16'(pick(-4, geo_w));
      it.clip_y = 16'(pick(-4, geo_h));
      it.clip_w = 16'(pick(-6, geo_w + 4));
      it.clip_h = 16'(pick(-6, geo_h + 4));
    end else begin
      // Area stays small: a random destination size is always negative here.
      it.clip_x = 16'($urandom);
      it.clip_y = 16'($urandom);
      it.clip_w = 16'($urandom);
      it.clip_h = 16'($urandom);
      if ($urandom_range(0, 1)) it.dest_x = 16'($urandom);
      if ($urandom_range(0, 1)) it.dest_y = 16'($urandom);
      if ($urandom_range(0, 2) == 0) it.dest_w = 16'($urandom) | 16'h8000;
      if ($urandom_range(0, 2) == 0) it.dest_h = 16'($urandom) | 16'h8000;
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int gap;
    gap = steady_run ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= it.op;
    dest_x_i     <= it.dest_x;
    dest_y_i     <= it.dest_y;
    dest_w_i     <= it.dest_w;
    dest_h_i     <= it.dest_h;
    clip_x_i     <= it.clip_x;
    clip_y_i     <= it.clip_y;
    clip_w_i     <= it.clip_w;
    clip_h_i     <= it.clip_h;
    blend_i      <= it.blend;
    fill_value_i <= it.fill_value;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold off the item channel until every result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  task automatic set_geometry(input int w, input int h);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_BUFFER_WIDTH;
    cfg_data_i <= 9'(w);
    @(posedge clk_i);
    cfg_idx_i  <= REG_BUFFER_HEIGHT;
    cfg_data_i <= 9'(h);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    geo_w = (w > MAX_WIDTH) ? MAX_WIDTH : w;
    geo_h = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
  endtask

  // Result side: at random, raise the stall before a result and keep it up past its arrival; steady runs never stall.
  initial begin
    int hold;
    forever begin
      hold = steady_run ? 0 : $urandom_range(0, 18);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        do @(posedge clk_i); while (!out_valid_o);
        repeat (hold - 1) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    steady_run   = 1'b0;
    geo_w        = MAX_WIDTH;
    geo_h        = MAX_HEIGHT;
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= REG_BUFFER_WIDTH;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    op_i         <= OP_FILL;
    dest_x_i     <= '0;
    dest_y_i     <= '0;
    dest_w_i     <= '0;
    dest_h_i     <= '0;
    clip_x_i     <= '0;
    clip_y_i     <= '0;
    clip_w_i     <= '0;
    clip_h_i     <= '0;
    blend_i      <= BLEND_REPLACE;
    fill_value_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_geometry(256, 256);

    send_item(read_cmd(0, 0));
    send_item(fill_cmd(0, 0, 256, 256, 0, 0, 256, 256, BLEND_REPLACE, 8'h37));
    send_item(read_cmd(255, 255));
    send_item(fill_cmd(10, 10, 5, 5, 0, 0, 256, 256, BLEND_REPLACE, FULL_LEVEL));
    send_item(fill_cmd(8, 8, 10, 10, 0, 0, 256, 256, BLEND_KEEP_LIT, 8'h80));
    send_item(read_cmd(10, 10));
    send_item(read_cmd(9, 9));
    send_item(fill_cmd(0, 0, 64, 64, 0, 0, 256, 256, BLEND_NOP_A, 8'h00));
    send_item(fill_cmd(0, 0, 64, 64, 0, 0, 256, 256, BLEND_NOP_B, 8'h01));
    send_item(read_cmd(12, 12));
    // clip end lands below zero: nothing to write
    send_item(fill_cmd(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767,
                       BLEND_REPLACE, 8'hA5));
    send_item(fill_cmd(32767, 32767, 32767, 32767, 0, 0, 32767, 32767,
                       BLEND_REPLACE, 8'h5A));
    // sums past the 16-bit range, clamped to the buffer edges
    send_item(fill_cmd(200, -5, 32767, 10, 0, 0, 32767, 32767, BLEND_REPLACE, 8'h00));
    send_item(read_cmd(255, 4));
    // negative clip size with a negative width leaves a partial span
    send_item(fill_cmd(22, 22, -5, -5, 20, 20, -4, -4, BLEND_REPLACE, 8'hC3));
    send_item(read_cmd(17, 17));
    send_item(fill_cmd(5, 5, 0, -3, 0, 0, 256, 256, BLEND_REPLACE, 8'hFF));
    send_item(read_cmd(-1, 0));
    send_item(read_cmd(256, 3));
    send_item(read_cmd(3, 256));
    send_item(read_cmd(-32768, 32767));
    send_item(bare_cmd(OP_UNUSED));
    send_item(bare_cmd(OP_CLEAR));
    send_item(read_cmd(10, 10));
    drain_results();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      set_geometry((ph == N_PHASES - 1) ? pick(1, 256) : phase_w[ph],
                   (ph == N_PHASES - 1) ? pick(1, 256) : phase_h[ph]);
      steady_run = (ph % 3 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_item());
        if ($urandom_range(0, 49) == 0) drain_results();
      end
      drain_results();
    end

    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #120_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
